// ===== hdl/linear_probe_hash_table_core_defines.svh =====
// assertion macros used by the hash table datapath
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_DEFINES_SVH

`ifndef SYNTH

// condition holds at every edge out of reset
`define LPHT_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("lpht assertion failed");

// consequent holds in the same cycle as the antecedent
`define LPHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lpht implication failed");

// consequent holds in the cycle after the antecedent
`define LPHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lpht next-cycle implication failed");

`else

`define LPHT_ASSERT(lbl, clk, rst_n, cond)
`define LPHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LPHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/lpht_pkg.sv =====
`default_nettype none

package lpht_pkg;

    localparam int SLOTS      = 1024;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int CNT_BITS   = SLOT_BITS + 1;
    localparam int KEY_BITS   = 32;
    localparam int DATA_BITS  = 32;
    localparam int LIMIT_BITS = 10;
    localparam int HASH_BITS  = 32;
    localparam int FUNC_BITS  = 2;
    localparam int STAT_BITS  = 2;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(512);

    typedef logic [SLOT_BITS-1:0] t_slot;
    typedef logic [CNT_BITS-1:0]  t_cnt;
    typedef logic [KEY_BITS-1:0]  t_key;
    typedef logic [DATA_BITS-1:0] t_data;

    // operation codes, the spare code behaves as a lookup
    localparam logic [FUNC_BITS-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 2'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_SPARE  = 2'd3;

    // result status codes
    localparam logic [STAT_BITS-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_BITS-1:0] STAT_MISS   = 2'd1;
    localparam logic [STAT_BITS-1:0] STAT_EXISTS = 2'd2;
    localparam logic [STAT_BITS-1:0] STAT_FULL   = 2'd3;

    // one slot of the table
    typedef struct packed {
        logic  valid;
        t_slot home;
        t_key  key;
        t_data data;
    } t_entry;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PRB_RD,
        S_PRB_CHK,
        S_SH_RD,
        S_SH_CHK,
        S_SH_END,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic load;
        logic rd_j;
        logic prb_adv;
        logic fin_probe;
        logic fin_insert;
        logic sh_init;
        logic sh_chk;
        logic sh_end;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic                 clr_last;
        logic                 hit;
        logic                 empty;
        logic                 prb_last;
        logic                 sh_last;
        logic                 out_free;
        logic [FUNC_BITS-1:0] func;
    } t_sts;

endpackage

`default_nettype wire

// ===== hdl/lpht_req_if.sv =====
`default_nettype none

interface lpht_req_if;
    import lpht_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [FUNC_BITS-1:0] func;
    logic                 replace;
    t_key                 key;
    logic [HASH_BITS-1:0] key_hash;
    t_data                data;

    modport source (output valid, func, replace, key, key_hash, data, input ready);
    modport sink   (input valid, func, replace, key, key_hash, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/lpht_rsp_if.sv =====
`default_nettype none

interface lpht_rsp_if;
    import lpht_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STAT_BITS-1:0] status;
    t_slot                slot;
    t_data                data_out;
    t_cnt                 fill_count;

    modport source (output valid, status, slot, data_out, fill_count, input ready);
    modport sink   (input valid, status, slot, data_out, fill_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/lpht_ram.sv =====
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/lpht_ctrl.sv =====
`default_nettype none

module lpht_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire lpht_pkg::t_sts i_sts,
    output lpht_pkg::t_cmd     o_cmd
);
    import lpht_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   terminal;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign terminal = i_sts.hit || i_sts.empty || i_sts.prb_last;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PRB_RD;
                end
            end
            S_PRB_RD: begin
                n_state = S_PRB_CHK;
            end
            S_PRB_CHK: begin
                if (!terminal) begin
                    o_cmd.prb_adv = 1'b1;
                    n_state       = S_PRB_RD;
                end else begin
                    case (i_sts.func)
                        FUNC_INSERT: begin
                            o_cmd.fin_insert = 1'b1;
                            n_state          = S_DONE;
                        end
                        FUNC_REMOVE: begin
                            if (i_sts.hit) begin
                                o_cmd.sh_init = 1'b1;
                                n_state       = S_SH_RD;
                            end else begin
                                o_cmd.fin_probe = 1'b1;
                                n_state         = S_DONE;
                            end
                        end
                        default: begin
                            o_cmd.fin_probe = 1'b1;
                            n_state         = S_DONE;
                        end
                    endcase
                end
            end
            S_SH_RD: begin
                o_cmd.rd_j = 1'b1;
                n_state    = S_SH_CHK;
            end
            S_SH_CHK: begin
                o_cmd.rd_j = 1'b1;
                if (i_sts.empty) begin
                    n_state = S_SH_END;
                end else begin
                    o_cmd.sh_chk = 1'b1;
                    n_state      = i_sts.sh_last ? S_SH_END : S_SH_RD;
                end
            end
            S_SH_END: begin
                o_cmd.sh_end = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/lpht_dpath.sv =====
`default_nettype none
`include "linear_probe_hash_table_core_defines.svh"

module lpht_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lpht_pkg::t_cmd                i_cmd,
    output lpht_pkg::t_sts                     o_sts,
    input  wire logic [lpht_pkg::FUNC_BITS-1:0] i_func,
    input  wire logic                          i_replace,
    input  wire lpht_pkg::t_key                i_key,
    input  wire logic [lpht_pkg::HASH_BITS-1:0] i_key_hash,
    input  wire lpht_pkg::t_data               i_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [lpht_pkg::LIMIT_BITS-1:0] i_cfg_wdata,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [lpht_pkg::STAT_BITS-1:0]     o_status,
    output lpht_pkg::t_slot                    o_slot,
    output lpht_pkg::t_data                    o_data_out,
    output lpht_pkg::t_cnt                     o_fill_count
);
    import lpht_pkg::*;

    // request registers
    logic [FUNC_BITS-1:0]  r_func;
    logic                  r_replace;
    t_key                  r_key;
    t_slot                 r_start;
    t_data                 r_data;
    // probe and shift walkers
    t_slot                 r_pos;
    t_slot                 r_n;
    t_slot                 r_hole;
    t_slot                 r_j;
    t_slot                 r_clr;
    // table bookkeeping
    t_cnt                  r_count;
    logic [LIMIT_BITS-1:0] r_limit;
    // staged result
    logic [STAT_BITS-1:0]  r_st;
    t_slot                 r_slot;
    t_data                 r_dout;
    logic                  r_out_valid;

    t_entry rd;
    t_entry wdata;
    t_slot  waddr;
    t_slot  raddr;
    logic   we;
    logic   hit;
    logic   full;
    logic   movable;

    assign raddr   = i_cmd.rd_j ? r_j : r_pos;
    assign hit     = rd.valid && (rd.key == r_key);
    assign full    = r_count >= {1'b0, r_limit};
    // entry may fill the hole if its home lies no later than the hole
    assign movable = (r_j - rd.home) >= (r_j - r_hole);

    // table write port
    always_comb begin
        we    = 1'b0;
        waddr = r_pos;
        wdata = rd;
        if (i_cmd.clr_wr) begin
            we    = 1'b1;
            waddr = r_clr;
            wdata = '0;
        end else if (i_cmd.fin_insert) begin
            if (hit) begin
                we         = r_replace;
                wdata.data = r_data;
            end else begin
                we    = !full && rd.valid == 1'b0;
                wdata = '{valid: 1'b1, home: r_start, key: r_key, data: r_data};
            end
        end else if (i_cmd.sh_chk) begin
            we    = movable;
            waddr = r_hole;
        end else if (i_cmd.sh_end) begin
            we    = 1'b1;
            waddr = r_hole;
            wdata = '0;
        end
    end

    lpht_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_count     <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.fin_insert && !hit && !full && !rd.valid) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.sh_end && r_count != '0) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= i_func;
            r_replace <= i_replace;
            r_key     <= i_key;
            r_data    <= i_data;
            r_start   <= i_key_hash[SLOT_BITS-1:0];
            r_pos     <= i_key_hash[SLOT_BITS-1:0];
            r_n       <= '0;
        end
        if (i_cmd.prb_adv) begin
            r_pos <= r_pos + 1'b1;
            r_n   <= r_n + 1'b1;
        end
        if (i_cmd.fin_probe) begin
            r_st   <= hit ? STAT_OK : STAT_MISS;
            r_slot <= hit ? r_pos : '0;
            r_dout <= hit ? rd.data : '0;
        end
        if (i_cmd.fin_insert) begin
            if (hit) begin
                r_st   <= r_replace ? STAT_OK : STAT_EXISTS;
                r_slot <= r_pos;
                r_dout <= r_replace ? r_data : rd.data;
            end else if (full || !rd.valid == 1'b0) begin
                r_st   <= STAT_FULL;
                r_slot <= '0;
                r_dout <= '0;
            end else begin
                r_st   <= STAT_OK;
                r_slot <= r_pos;
                r_dout <= r_data;
            end
        end
        if (i_cmd.sh_init) begin
            r_st   <= STAT_OK;
            r_slot <= r_pos;
            r_dout <= rd.data;
            r_hole <= r_pos;
            r_j    <= r_pos + 1'b1;
            r_n    <= SLOT_BITS'(1);
        end
        if (i_cmd.sh_chk) begin
            if (movable) begin
                r_hole <= r_j;
            end
            r_j <= r_j + 1'b1;
            r_n <= r_n + 1'b1;
        end
        if (i_cmd.emit) begin
            o_status     <= r_st;
            o_slot       <= r_slot;
            o_data_out   <= r_dout;
            o_fill_count <= r_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.clr_last = r_clr == SLOT_BITS'(SLOTS - 1);
    assign o_sts.hit      = hit;
    assign o_sts.empty    = !rd.valid;
    assign o_sts.prb_last = r_n == SLOT_BITS'(SLOTS - 1);
    assign o_sts.sh_last  = r_n == SLOT_BITS'(SLOTS - 1);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.func     = r_func;

    `LPHT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_BITS'(SLOTS))
    `LPHT_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, i_cmd.emit, !r_out_valid || i_out_ready)
    `LPHT_ASSERT_IMP(a_remove_nonempty, i_clk, i_rst_n, i_cmd.sh_end, r_count != '0)
    `LPHT_ASSERT_NXT(a_emit_shows, i_clk, i_rst_n, i_cmd.emit, r_out_valid)

endmodule

`default_nettype wire

// ===== hdl/linear_probe_hash_table_core.sv =====
// channel  dir  handshake      payload
// i_req    in   valid/ready    func, replace, key, key_hash, data
// o_rsp    out  valid/ready    status, slot, data_out, fill_count
// i_cfg    in   i_cfg_we       i_cfg_wdata (fill limit)
//
// each probed slot passes a read state and a check state (one table read port, registered read)
// remove adds a read and a check state per slot scanned in the backward shift, then an end state
// a request runs its probes, then the shift for a remove, then waits in the done state
// after reset a clearing pass writes every slot before the first transfer
// a finished result waits in the output register while the next request is taken
`default_nettype none

module linear_probe_hash_table_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    lpht_req_if.sink                             i_req,
    lpht_rsp_if.source                           o_rsp,
    input  wire logic                            i_cfg_we,
    input  wire logic [lpht_pkg::LIMIT_BITS-1:0] i_cfg_wdata
);
    import lpht_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lpht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lpht_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_func       (i_req.func),
        .i_replace    (i_req.replace),
        .i_key        (i_req.key),
        .i_key_hash   (i_req.key_hash),
        .i_data       (i_req.data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_status     (o_rsp.status),
        .o_slot       (o_rsp.slot),
        .o_data_out   (o_rsp.data_out),
        .o_fill_count (o_rsp.fill_count)
    );

endmodule

`default_nettype wire
